/* sv/fpf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpf_pkg
// Shared constants, types and CRC helper for the FSK packet framer.
// ----------------------------------------------------------------------------
package fpf_pkg;

    // Frame geometry
    localparam int PAYLOAD_LEN  = 8;    // 1..15
    localparam int PREAMBLE_LEN = 4;    // 1..8
    localparam int SYNC_LEN     = 4;    // 1..4
    localparam int WHITE_LEN    = 18;

    // Payload store addressing
    localparam int IDX_W = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;

    // Byte counter and frame index width (fixed by the frame size limit)
    localparam int CNT_W = 5;

    localparam logic [CNT_W-1:0] LEN_C      = CNT_W'(PAYLOAD_LEN);
    localparam logic [CNT_W-1:0] LEN_M1_C   = CNT_W'(PAYLOAD_LEN - 1);
    localparam logic [CNT_W-1:0] LEN_OVF_C  = CNT_W'(PAYLOAD_LEN + 1);
    localparam logic [CNT_W-1:0] PRE_END_C  = CNT_W'(PREAMBLE_LEN);
    localparam logic [CNT_W-1:0] SYNC_END_C = CNT_W'(PREAMBLE_LEN + SYNC_LEN);
    localparam logic [CNT_W-1:0] CRC_HI_C   = CNT_W'(PAYLOAD_LEN + 1);

    // Configuration register indexes
    localparam logic CFG_PREAMBLE = 1'b0;
    localparam logic CFG_SYNC     = 1'b1;

    // CRC-16
    localparam logic [15:0] CRC_INIT = 16'h1D0F;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // PN9 whitening sequence
    localparam logic [7:0] PN9 [WHITE_LEN] = '{
        8'hff, 8'h87, 8'hb8, 8'h59, 8'hb7, 8'ha1, 8'hcc, 8'h24, 8'h57,
        8'h5e, 8'h4b, 8'h9c, 8'h0e, 8'he9, 8'hea, 8'h50, 8'h2a, 8'hbe
    };

    // Bitwise CRC-16 update, MSB first
    function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        logic [7:0]  d;
        logic        fb;
        c = crc;
        d = b;
        for (int k = 0; k < 8; k++) begin
            fb = c[15] ^ d[7];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
            d = {d[6:0], 1'b0};
        end
        return c;
    endfunction

    // CRC after the length byte, start value of every frame
    localparam logic [15:0] CRC_START = crc_byte(CRC_INIT, 8'(PAYLOAD_LEN));

    // Frame start request from the receive side to the transmit sequencer
    typedef struct packed {
        logic        valid;
        logic        err;
        logic [15:0] crc;     // already complemented
    } t_tx_start;

endpackage

/* sv/fpf_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpf_store
// Payload byte memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fpf_store (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [fpf_pkg::IDX_W-1:0] i_waddr,
    input  logic [7:0]                i_wdata,
    input  logic [fpf_pkg::IDX_W-1:0] i_raddr,
    output logic [7:0]                o_rdata
);
    import fpf_pkg::*;

    logic [7:0] r_mem [PAYLOAD_LEN];
    logic [7:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/fpf_tx.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpf_tx
// Frame transmit sequencer: walks the frame byte by byte, reads payload from
// the store, whitens and drives the output register, or sends the error result.
// ----------------------------------------------------------------------------
module fpf_tx (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  fpf_pkg::t_tx_start        i_start,
    input  logic [7:0]                i_preamble_byte,
    input  logic [31:0]               i_sync_word,
    output logic [fpf_pkg::IDX_W-1:0] o_raddr,
    input  logic [7:0]                i_rdata,
    output logic                      o_busy,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [7:0]                o_frame_byte,
    output logic                      o_frame_last,
    output logic                      o_length_error
);
    import fpf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_FORM  = 4'b0100,
        S_SEND  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [15:0]      r_crc;
    logic [7:0]       r_byte, n_byte;
    logic             r_last, n_last;
    logic             r_err, n_err;

    logic [CNT_W-1:0] w_pos;
    logic [CNT_W-1:0] w_sync_sel;
    logic [CNT_W-1:0] w_rd_pos;

    // Position inside the whitened part (length byte is position 0)
    assign w_pos      = r_idx - SYNC_END_C;
    assign w_sync_sel = r_idx - PRE_END_C;
    assign w_rd_pos   = w_pos - CNT_W'(1);
    assign o_raddr    = w_rd_pos[IDX_W-1:0];

    // Next-state and output byte formation
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_byte  = r_byte;
        n_last  = r_last;
        n_err   = r_err;
        unique case (r_state)
            S_IDLE: begin
                if (i_start.valid) begin
                    n_idx = '0;
                    if (i_start.err) begin
                        n_byte  = 8'h00;
                        n_last  = 1'b1;
                        n_err   = 1'b1;
                        n_state = S_SEND;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                // store read issued at this edge
                n_state = S_FORM;
            end
            S_FORM: begin
                n_last = 1'b0;
                n_err  = 1'b0;
                priority if (r_idx < PRE_END_C) begin
                    n_byte = i_preamble_byte;
                end else if (r_idx < SYNC_END_C) begin
                    n_byte = i_sync_word[8*w_sync_sel[1:0] +: 8];
                end else if (w_pos == '0) begin
                    n_byte = 8'(PAYLOAD_LEN) ^ PN9[w_pos];
                end else if (w_pos <= LEN_C) begin
                    n_byte = i_rdata ^ PN9[w_pos];
                end else if (w_pos == CRC_HI_C) begin
                    n_byte = r_crc[15:8] ^ PN9[w_pos];
                end else begin
                    n_byte = r_crc[7:0] ^ PN9[w_pos];
                    n_last = 1'b1;
                end
                n_state = S_SEND;
            end
            S_SEND: begin
                if (i_out_ready) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + CNT_W'(1);
                        n_state = S_FETCH;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_byte <= n_byte;
        r_last <= n_last;
        r_err  <= n_err;
        if (r_state == S_IDLE && i_start.valid) begin
            r_crc <= i_start.crc;
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_out_valid    = (r_state == S_SEND);
    assign o_frame_byte   = r_byte;
    assign o_frame_last   = r_last;
    assign o_length_error = r_err;

endmodule

/* sv/fsk_packet_framer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsk_packet_framer
// Packet framer for an FSK radio: preamble, sync, length, whitened payload
// and CRC-16, or a single length-error result.
// ----------------------------------------------------------------------------
// Payload bytes are taken one per cycle and written into an internal payload
// memory while a CRC-16 runs over them. The byte marked last starts the frame
// (or a single error result when the byte count is not PAYLOAD_LEN); while
// the frame streams out the input is held off. Each frame byte goes through
// an address step, a registered memory read and the output register, and
// then waits for the output to take it. A frame holds PREAMBLE_LEN +
// SYNC_LEN + PAYLOAD_LEN + 3 bytes. Configuration writes are accepted every
// cycle and must only be made while the block is idle.
// ----------------------------------------------------------------------------
module fsk_packet_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // payload input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_last_byte,
    // frame output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_frame_byte,
    output logic        o_frame_last,
    output logic        o_length_error
);
    import fpf_pkg::*;

    logic [7:0]       r_preamble_byte;
    logic [31:0]      r_sync_word;
    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_crc, n_crc;

    logic             w_in_acc;
    logic             w_store_we;
    logic [15:0]      w_crc_upd;
    logic             w_busy;
    logic [IDX_W-1:0] w_raddr;
    logic [7:0]       w_rdata;
    t_tx_start        w_start;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preamble_byte <= 8'hAA;
            r_sync_word     <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PREAMBLE: r_preamble_byte <= i_cfg_data[7:0];
                CFG_SYNC:     r_sync_word     <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // Input transaction; held off while a frame is in flight, so store
    // writes and sequencer reads never overlap
    assign o_in_ready = !w_busy;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_store_we = w_in_acc && (r_count < LEN_C);
    assign w_crc_upd  = crc_byte(r_crc, i_payload_byte);

    // Byte count and running CRC
    always_comb begin
        n_count = r_count;
        n_crc   = r_crc;
        if (w_in_acc) begin
            if (i_last_byte) begin
                n_count = '0;
                n_crc   = CRC_START;
            end else if (r_count < LEN_C) begin
                n_count = r_count + CNT_W'(1);
                n_crc   = w_crc_upd;
            end else begin
                n_count = LEN_OVF_C;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= CRC_START;
        end else begin
            r_count <= n_count;
            r_crc   <= n_crc;
        end
    end

    // Frame start: good only if this last byte is the PAYLOAD_LEN-th
    assign w_start.valid = w_in_acc && i_last_byte;
    assign w_start.err   = (r_count != LEN_M1_C);
    assign w_start.crc   = ~w_crc_upd;

    fpf_store u_store (
        .i_clk   (i_clk),
        .i_we    (w_store_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (i_payload_byte),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    fpf_tx u_tx (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (w_start),
        .i_preamble_byte (r_preamble_byte),
        .i_sync_word     (r_sync_word),
        .o_raddr         (w_raddr),
        .i_rdata         (w_rdata),
        .o_busy          (w_busy),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_frame_byte    (o_frame_byte),
        .o_frame_last    (o_frame_last),
        .o_length_error  (o_length_error)
    );

    // Assertions
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input accepted while a result is pending");

    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_last_byte && (r_count != LEN_M1_C))
            |=> (o_out_valid && o_length_error && o_frame_last))
        else $error("length error not reported");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_length_error) |-> (o_frame_last && (o_frame_byte == 8'h00)))
        else $error("malformed error result");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LEN_OVF_C)
        else $error("byte count out of range");

endmodule

/* test/fsk_packet_framer_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsk_packet_framer_test
// Self-checking testbench for the FSK packet framer.
// ----------------------------------------------------------------------------
// Payload bytes are driven on the input channel. A scoreboard predicts each
// frame from its own copy of the framer state: preamble, sync bytes, whitened
// length, payload and CRC. On a bad byte count it predicts one length-error
// transaction instead. Each output transaction is checked field by field in
// order. The run has three phases with different idle patterns on the input
// and output channels. The registers are reprogrammed between phases, only
// while the block is idle.
// ----------------------------------------------------------------------------
module fsk_packet_framer_test;
    import fpf_pkg::*;

    localparam int      SETTLE_CYCLES = 80;       // about one frame time
    localparam logic [15:0] CCITT_SEED = 16'h1D0F;
    localparam logic [15:0] CCITT_POLY = 16'h1021;

    // One output transaction
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
        logic       length_error;
    } t_frame_beat;

    // ------------------------------------------------------------------------
    // Frame predictor and output checker
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        logic [7:0]  preamble_val;
        logic [31:0] sync_val;
        logic [7:0]  payload_mem [PAYLOAD_LEN];
        logic [4:0]  rx_count;
        logic [15:0] crc_run;
        t_frame_beat expected_q [$];
        int unsigned mismatches;
        int unsigned beats_checked;
        int unsigned frames_seen;
        int unsigned length_errors;

        function new();
            preamble_val  = 8'hAA;
            sync_val      = '0;
            foreach (payload_mem[i]) payload_mem[i] = '0;
            mismatches    = 0;
            beats_checked = 0;
            frames_seen   = 0;
            length_errors = 0;
            restart();
        endfunction

        // CRC-16 CCITT, one byte, MSB first
        function logic [15:0] crc_step(logic [15:0] c, logic [7:0] d);
            logic fb;
            for (int k = 0; k < 8; k++) begin
                fb = c[15] ^ d[7];
                c  = {c[14:0], 1'b0};
                if (fb) begin
                    c = c ^ CCITT_POLY;
                end
                d = {d[6:0], 1'b0};
            end
            return c;
        endfunction

        // PN9 whitening byte by position in the whitened part (length byte is 0)
        function logic [7:0] whiten(int pos);
            unique case (pos % 18)
                0:  return 8'hff;
                1:  return 8'h87;
                2:  return 8'hb8;
                3:  return 8'h59;
                4:  return 8'hb7;
                5:  return 8'ha1;
                6:  return 8'hcc;
                7:  return 8'h24;
                8:  return 8'h57;
                9:  return 8'h5e;
                10: return 8'h4b;
                11: return 8'h9c;
                12: return 8'h0e;
                13: return 8'he9;
                14: return 8'hea;
                15: return 8'h50;
                16: return 8'h2a;
                default: return 8'hbe;
            endcase
        endfunction

        // Count and CRC go back to the start of a frame; the store is kept
        function void restart();
            rx_count = '0;
            crc_run  = crc_step(CCITT_SEED, 8'(PAYLOAD_LEN));
        endfunction

        function void push_beat(logic [7:0] b, logic l, logic e);
            t_frame_beat beat;
            beat.frame_byte   = b;
            beat.frame_last   = l;
            beat.length_error = e;
            expected_q.push_back(beat);
        endfunction

        function void set_reg(logic idx, logic [31:0] data);
            if (idx == CFG_PREAMBLE) begin
                preamble_val = data[7:0];
            end else begin
                sync_val = data;
            end
        endfunction

        // Accepted payload byte: absorb it, and on the last byte predict
        function void note_payload(logic [7:0] b, logic l);
            logic [15:0] crc_out;
            if (rx_count < PAYLOAD_LEN) begin
                payload_mem[rx_count] = b;
                crc_run  = crc_step(crc_run, b);
                rx_count = rx_count + 1'b1;
            end else begin
                rx_count = 5'(PAYLOAD_LEN + 1);   // overflow marker
            end
            if (!l) return;

            // wrong byte count: one error transaction, no frame
            if (rx_count != PAYLOAD_LEN) begin
                push_beat(8'h00, 1'b1, 1'b1);
                length_errors++;
                restart();
                return;
            end

            for (int i = 0; i < PREAMBLE_LEN; i++) push_beat(preamble_val, 1'b0, 1'b0);
            for (int i = 0; i < SYNC_LEN; i++)
                push_beat(sync_val[8 * (i % 4) +: 8], 1'b0, 1'b0);
            push_beat(8'(PAYLOAD_LEN) ^ whiten(0), 1'b0, 1'b0);
            for (int i = 0; i < PAYLOAD_LEN; i++)
                push_beat(payload_mem[i] ^ whiten(i + 1), 1'b0, 1'b0);
            crc_out = ~crc_run;
            push_beat(crc_out[15:8] ^ whiten(PAYLOAD_LEN + 1), 1'b0, 1'b0);
            push_beat(crc_out[7:0] ^ whiten(PAYLOAD_LEN + 2), 1'b1, 1'b0);
            frames_seen++;
            restart();
        endfunction

        // Accepted output transaction against the oldest expectation
        function void check_beat(logic [7:0] b, logic l, logic e);
            t_frame_beat want;
            if (expected_q.size() == 0) begin
                $error("unexpected output: frame_byte %02h frame_last %0b length_error %0b",
                       b, l, e);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            beats_checked++;
            if (b !== want.frame_byte) begin
                $error("frame_byte: expected %02h, actual %02h", want.frame_byte, b);
                mismatches++;
            end
            if (l !== want.frame_last) begin
                $error("frame_last: expected %0b, actual %0b", want.frame_last, l);
                mismatches++;
            end
            if (e !== want.length_error) begin
                $error("length_error: expected %0b, actual %0b", want.length_error, e);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals and instance
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_payload_byte;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_frame_byte;
    logic        o_frame_last;
    logic        o_length_error;

    fsk_packet_framer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_payload_byte (i_payload_byte),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_frame_byte   (o_frame_byte),
        .o_frame_last   (o_frame_last),
        .o_length_error (o_length_error)
    );

    frame_scoreboard sb;
    int unsigned     in_gap_pct;
    int unsigned     out_stall_pct;

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output side: check accepted transactions, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_beat(o_frame_byte, o_frame_last, o_length_error);
        end
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // One payload transaction; valid is left high after acceptance
    task automatic send_payload(input logic [7:0] b, input logic l);
        if ($urandom_range(99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_gap_pct);
        end
        i_in_valid     <= 1'b1;
        i_payload_byte <= b;
        i_last_byte    <= l;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_payload(b, l);
    endtask

    // One register write; valid is left high after acceptance
    task automatic write_reg(input logic idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic program_regs(input logic [7:0] pre, input logic [31:0] sync);
        write_reg(CFG_PREAMBLE, {24'($urandom()), pre});
        write_reg(CFG_SYNC, sync);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait for every expected transaction, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly well-formed frames with random content, some bad counts and noise
    task automatic random_traffic(input int n_items);
        int   sent;
        int   kind;
        int   len;
        logic l;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(99);
            if (kind < 75) begin
                len = PAYLOAD_LEN;
            end else if (kind < 92) begin
                len = $urandom_range(1, PAYLOAD_LEN + 4);
            end else begin
                len = $urandom_range(1, 3);
            end
            for (int i = 0; i < len; i++) begin
                l = (kind < 92) ? (i == len - 1) : 1'($urandom_range(1));
                send_payload(8'($urandom_range(255)), l);
            end
            sent += len;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb             = new();
        in_gap_pct     = 15;
        out_stall_pct  = 49;
        i_rst_n        <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= CFG_PREAMBLE;
        i_cfg_data     <= '0;
        i_in_valid     <= 1'b0;
        i_payload_byte <= '0;
        i_last_byte    <= 1'b0;
        i_out_ready    <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset register values: good frame of 00/FF bytes,
        // single-byte short frame, overflowing frame, then a clean frame
        for (int i = 0; i < PAYLOAD_LEN; i++)
            send_payload(i[0] ? 8'hFF : 8'h00, i == PAYLOAD_LEN - 1);
        send_payload(8'h5A, 1'b1);
        for (int i = 0; i < PAYLOAD_LEN + 1; i++)
            send_payload(8'(i * 37), i == PAYLOAD_LEN);
        for (int i = 0; i < PAYLOAD_LEN; i++)
            send_payload(8'($urandom_range(255)), i == PAYLOAD_LEN - 1);
        drain();

        // Phase 1: slow receiver, register extremes
        program_regs(8'h00, 32'hFFFF_FFFF);
        random_traffic(30);
        drain();

        // Phase 2: slow sender, opposite extremes
        in_gap_pct    = 49;
        out_stall_pct = 15;
        program_regs(8'hFF, 32'h0000_0000);
        random_traffic(30);
        drain();

        // Phase 3: no idling, random registers
        in_gap_pct    = 0;
        out_stall_pct = 0;
        program_regs(8'($urandom()), $urandom());
        random_traffic(30);
        drain();

        $display("Covered %0d frames and %0d length errors, %0d output transactions checked",
                 sb.frames_seen, sb.length_errors, sb.beats_checked);
        $display("across three idle patterns and four register settings.");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("fsk_packet_framer_test: PASS");
        end else begin
            $display("fsk_packet_framer_test: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("fsk_packet_framer_test: FAIL");
        $finish;
    end

endmodule
